// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Tile sprite compositor package
// Shared request, pixel and texel types and register and mode codes.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int COORD_W = 11;
  localparam int SIZE_W  = 4;
  localparam int COUNT_W = 6;
  localparam int COLOR_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_RENDER = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_WIDTH   = 3'd0,
    CFG_CELL_HEIGHT  = 3'd1,
    CFG_BG_RED       = 3'd2,
    CFG_BG_GREEN     = 3'd3,
    CFG_BG_BLUE      = 3'd4,
    CFG_SPRITE_COUNT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic        mode;
    logic [4:0]  sprite_index;
    logic [2:0]  texel_row;
    logic [2:0]  texel_col;
    logic [7:0]  texel_red;
    logic [7:0]  texel_green;
    logic [7:0]  texel_blue;
    logic        texel_opaque;
    logic [31:0] object_bits;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
  } in_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } out_pix_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic opaque;
    rgb_t color;
  } texel_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last;
  } pix_issue_t;

endpackage

// File: rtl/tsc_texel_mem.sv
// ----------------------------------------------------------------------------
// Texel store
// One row per texel position, one lane per sprite, lane write enables and
// a registered read of a whole row.
// ----------------------------------------------------------------------------
module tsc_texel_mem
  import tsc_pkg::*;
#(
  parameter int LANES = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [LANES-1:0]       wlane,
  input  texel_t                 wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output texel_t [LANES-1:0]     rdata
);

  texel_t [LANES-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int l = 0; l < LANES; l++) begin
        if (wlane[l]) begin
          mem[waddr][l] <= wdata;
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tsc_cell_seq.sv
// ----------------------------------------------------------------------------
// Cell sequencer
// Clears the store after reset, writes loaded texels and walks the pixels
// of a rendered cell, issuing one row read per pixel.
// ----------------------------------------------------------------------------
module tsc_cell_seq
  import tsc_pkg::*;
#(
  parameter int MAX_OBJECTS   = 32,
  parameter int MAX_CELL_SIZE = 8,
  parameter int DEPTH         = 64,
  parameter int AW            = 6,
  parameter int CNT_W         = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_req_t                 in_req,
  input  logic [SIZE_W-1:0]       cell_width,
  input  logic [SIZE_W-1:0]       cell_height,
  input  logic [COUNT_W-1:0]      sprite_count,
  input  logic                    slot_free,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [MAX_OBJECTS-1:0]  mem_wlane,
  output texel_t                  mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  output pix_issue_t              issue,
  output logic [MAX_OBJECTS-1:0]  obj_mask
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } seq_state_t;

  seq_state_t         state;
  logic [AW-1:0]      clr_addr;
  logic [CNT_W-1:0]   row;
  logic [CNT_W-1:0]   col;
  logic [SIZE_W-1:0]  w;
  logic [SIZE_W-1:0]  h;
  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;

  logic                   accept;
  logic                   load_ok;
  logic                   issue_go;
  logic                   col_end;
  logic                   row_end;
  logic [SIZE_W-1:0]      w_sat;
  logic [SIZE_W-1:0]      h_sat;
  logic [COUNT_W-1:0]     n_sat;
  logic [MAX_OBJECTS-1:0] lim_mask;

  assign in_ready = (state == ST_IDLE) && slot_free;
  assign accept   = in_valid && in_ready;
  assign load_ok  = accept && (in_req.mode == MODE_LOAD)
                    && (int'(in_req.sprite_index) < MAX_OBJECTS)
                    && (int'(in_req.texel_row) < MAX_CELL_SIZE)
                    && (int'(in_req.texel_col) < MAX_CELL_SIZE);

  always_comb begin
    if (cell_width == '0) begin
      w_sat = SIZE_W'(1);
    end else if (int'(cell_width) > MAX_CELL_SIZE) begin
      w_sat = SIZE_W'(MAX_CELL_SIZE);
    end else begin
      w_sat = cell_width;
    end
    if (cell_height == '0) begin
      h_sat = SIZE_W'(1);
    end else if (int'(cell_height) > MAX_CELL_SIZE) begin
      h_sat = SIZE_W'(MAX_CELL_SIZE);
    end else begin
      h_sat = cell_height;
    end
    if (int'(sprite_count) > MAX_OBJECTS) begin
      n_sat = COUNT_W'(MAX_OBJECTS);
    end else begin
      n_sat = sprite_count;
    end
    for (int k = 0; k < MAX_OBJECTS; k++) begin
      lim_mask[k] = (k < int'(n_sat));
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wlane = '1;
      mem_wdata = '0;
    end else begin
      mem_we    = load_ok;
      mem_waddr = AW'(int'(in_req.texel_row) * MAX_CELL_SIZE + int'(in_req.texel_col));
      mem_wlane = MAX_OBJECTS'(1) << in_req.sprite_index;
      mem_wdata = '{opaque: in_req.texel_opaque,
                    color: '{red: in_req.texel_red, green: in_req.texel_green,
                             blue: in_req.texel_blue}};
    end
  end

  assign issue_go  = (state == ST_RUN) && slot_free;
  assign col_end   = (SIZE_W'(col) == w - SIZE_W'(1));
  assign row_end   = (SIZE_W'(row) == h - SIZE_W'(1));
  assign mem_raddr = AW'(int'(row) * MAX_CELL_SIZE + int'(col));

  always_comb begin
    issue.valid   = issue_go;
    issue.pixel_x = base_x + COORD_W'(col);
    issue.pixel_y = base_y + COORD_W'(row);
    issue.last    = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (in_req.mode == MODE_RENDER)) begin
            state    <= ST_RUN;
            row      <= '0;
            col      <= '0;
            w        <= w_sat;
            h        <= h_sat;
            base_x   <= COORD_W'(12'(in_req.cell_x) * 12'(w_sat));
            base_y   <= COORD_W'(12'(in_req.cell_y) * 12'(h_sat));
            obj_mask <= in_req.object_bits[MAX_OBJECTS-1:0] & lim_mask;
          end
        end
        ST_RUN: begin
          if (issue_go) begin
            if (col_end) begin
              col <= '0;
              row <= row + CNT_W'(1);
              if (row_end) begin
                state <= ST_IDLE;
              end
            end else begin
              col <= col + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// File: rtl/tsc_pixel_resolve.sv
// ----------------------------------------------------------------------------
// Pixel resolver
// Picks the highest present opaque sprite lane of a texel row, or the
// background, and holds the finished pixel in the output register.
// ----------------------------------------------------------------------------
module tsc_pixel_resolve
  import tsc_pkg::*;
#(
  parameter int LANES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  pix_issue_t          issue,
  input  texel_t [LANES-1:0]  rdata,
  input  logic [LANES-1:0]    obj_mask,
  input  rgb_t                bg,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output out_pix_t            out_pix
);

  logic       pend;
  pix_issue_t pend_info;
  logic       advance;
  rgb_t       color;

  assign advance   = pend && (!out_valid || out_ready);
  assign slot_free = !pend || advance;

  always_comb begin
    color = bg;
    for (int k = 0; k < LANES; k++) begin
      if (obj_mask[k] && rdata[k].opaque) begin
        color = rdata[k].color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        pend      <= issue.valid;
        pend_info <= issue;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        out_pix.pixel_x <= pend_info.pixel_x;
        out_pix.pixel_y <= pend_info.pixel_y;
        out_pix.red     <= color.red;
        out_pix.green   <= color.green;
        out_pix.blue    <= color.blue;
        out_pix.last    <= pend_info.last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/tile_sprite_compositor.sv
// ----------------------------------------------------------------------------
// Tile sprite compositor
// Loads sprite texels into a texel store and renders grid cells into
// streams of composited pixels.
//
//   Channel   Direction  Handshake              Payload
//   in        request    in_valid / in_ready    in_req (in_req_t)
//   out       result     out_valid / out_ready  out_pix (out_pix_t)
//   cfg       write      cfg_write              cfg_index, cfg_data
//
// A load request writes its texel when accepted. A render request yields
// width times height pixels, one per cycle (a stalled output holds the
// pipeline in place), each read from one store row holding that position for
// every sprite and passed through the sequencer state, the registered row read
// and the output register. After reset the store, MAX_CELL_SIZE squared rows
// (64 by default), is cleared one row a cycle, then requests are taken.
// ----------------------------------------------------------------------------
module tile_sprite_compositor
  import tsc_pkg::*;
#(
  parameter int MAX_OBJECTS   = 32,
  parameter int MAX_CELL_SIZE = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_pix_t              out_pix,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_CELL_SIZE * MAX_CELL_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;

  logic [SIZE_W-1:0]  cell_width;
  logic [SIZE_W-1:0]  cell_height;
  logic [COUNT_W-1:0] sprite_count;
  rgb_t               bg;

  logic                      slot_free;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [MAX_OBJECTS-1:0]    mem_wlane;
  texel_t                    mem_wdata;
  logic [AW-1:0]             mem_raddr;
  texel_t [MAX_OBJECTS-1:0]  mem_rdata;
  pix_issue_t                issue;
  logic [MAX_OBJECTS-1:0]    obj_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= SIZE_W'(5);
      cell_height  <= SIZE_W'(5);
      bg           <= '0;
      sprite_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CELL_WIDTH:   cell_width   <= cfg_data[SIZE_W-1:0];
        CFG_CELL_HEIGHT:  cell_height  <= cfg_data[SIZE_W-1:0];
        CFG_BG_RED:       bg.red       <= cfg_data;
        CFG_BG_GREEN:     bg.green     <= cfg_data;
        CFG_BG_BLUE:      bg.blue      <= cfg_data;
        CFG_SPRITE_COUNT: sprite_count <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tsc_cell_seq #(
    .MAX_OBJECTS  (MAX_OBJECTS),
    .MAX_CELL_SIZE(MAX_CELL_SIZE),
    .DEPTH        (DEPTH),
    .AW           (AW),
    .CNT_W        (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .cell_width  (cell_width),
    .cell_height (cell_height),
    .sprite_count(sprite_count),
    .slot_free   (slot_free),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wlane   (mem_wlane),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .issue       (issue),
    .obj_mask    (obj_mask)
  );

  tsc_texel_mem #(
    .LANES(MAX_OBJECTS),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wlane(mem_wlane),
    .wdata(mem_wdata),
    .re   (issue.valid),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  tsc_pixel_resolve #(
    .LANES(MAX_OBJECTS)
  ) u_resolve (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .rdata    (mem_rdata),
    .obj_mask (obj_mask),
    .bg       (bg),
    .slot_free(slot_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pix  (out_pix)
  );

endmodule
